@@ src/fcrq_pkg.sv @@
package fcrq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0] TIMEOUT_RESET = 8'd100;

   typedef enum logic [1:0] {
      MODE_BYTE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_POP  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      LEVEL_EMPTY     = 2'd0,
      LEVEL_NORMAL    = 2'd1,
      LEVEL_OVER_HALF = 2'd2,
      LEVEL_FULL      = 2'd3
   } level_type;

   typedef struct packed {
      logic        null_flag;
      logic [15:0] sequence_num;
      logic [7:0]  command;
   } entry_type;

   // per-cell control: shift toward the head, or load a new entry here
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic level_type level_of(input logic [CNT_W-1:0] count);
      level_type lvl;
      if (count == '0) begin
         lvl = LEVEL_EMPTY;
      end else if (count <= CNT_W'(QUEUE_DEPTH / 2)) begin
         lvl = LEVEL_NORMAL;
      end else if (count < CNT_W'(QUEUE_DEPTH)) begin
         lvl = LEVEL_OVER_HALF;
      end else begin
         lvl = LEVEL_FULL;
      end
      return lvl;
   endfunction

endpackage

@@ src/fcrq_cell.sv @@
module fcrq_cell
   import fcrq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     load_data,
   input  entry_type     next_data,
   output entry_type     data
);

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ src/fcrq_chain.sv @@
module fcrq_chain
   import fcrq_pkg::*;
(
   input  logic             clock,
   input  logic             push,
   input  logic             pop,
   input  logic [CNT_W-1:0] fill_count,
   input  entry_type        push_data,
   output entry_type        head
);

   entry_type entries [QUEUE_DEPTH];

   // cell 0 holds the oldest entry; a pop moves every cell one step toward it
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     next_data;

      assign ctrl.shift = pop;
      assign ctrl.load  = push && (fill_count == CNT_W'(i));

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_data = entries[i];
      end else begin : g_body
         assign next_data = entries[i + 1];
      end

      fcrq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (push_data),
         .next_data (next_data),
         .data      (entries[i])
      );
   end

   assign head = entries[0];

endmodule

@@ src/framed_command_receive_queue_unit.sv @@
// Framed command receive queue.
// req channel: one item per transfer, req_mode selects received byte (0),
//   timer tick (1), pop of the oldest command (2) or no operation (3);
//   req_rx_byte carries the UART byte for mode 0.
// rsp channel: exactly one result per request, in the cycle after the request
//   transfer, held in an output register until rsp_ready takes it.
// csr channel: writes timeout_reload (ticks allowed between the zero sync
//   byte and the command byte); always ready. Write only while idle.
// Throughput: one request per cycle while results are taken. req_ready is
//   high while the output register is empty or being drained in the same
//   cycle, so a stalled receiver holds back at most one result and then
//   stalls the sender.
// Storage: a row of QUEUE_DEPTH entry cells; a push loads the cell at the
//   fill count, a pop shifts every cell one step toward the head.
// Reset (synchronous): idle, timeout 0, queue empty, sequence 0,
//   timeout_reload 100, no result pending. Cell contents are not cleared.
module framed_command_receive_queue_unit
   import fcrq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_queue_level,
   output logic        rsp_pop_valid,
   output logic        rsp_pop_empty_error,
   output logic [7:0]  rsp_out_command,
   output logic [15:0] rsp_out_sequence,
   output logic        rsp_out_null_flag,
   output logic        rsp_framing_error,
   output logic        rsp_dropped_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_timeout_reload
);

   // control state
   logic [7:0]       reload_ff, reload_in;
   logic             armed_ff, armed_in;
   logic [7:0]       timeout_ff, timeout_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [15:0]      sequence_ff, sequence_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [1:0]  level_ff, level_in;
   logic        pop_valid_ff, pop_valid_in;
   logic        pop_empty_ff, pop_empty_in;
   entry_type   popped_ff, popped_in;
   logic        framing_ff, framing_in;
   logic        dropped_ff, dropped_in;

   logic        req_accept;
   logic        push;
   logic        pop;
   logic        queue_full;
   entry_type   push_data;
   entry_type   head;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign queue_full = (fill_count_ff == CNT_W'(QUEUE_DEPTH));

   assign push_data.command      = req_rx_byte;
   assign push_data.sequence_num = sequence_ff;
   assign push_data.null_flag    = (req_rx_byte == 8'd0);

   always_comb begin
      reload_in     = reload_ff;
      armed_in      = armed_ff;
      timeout_in    = timeout_ff;
      fill_count_in = fill_count_ff;
      sequence_in   = sequence_ff;
      push          = 1'b0;
      pop           = 1'b0;
      pop_valid_in  = 1'b0;
      pop_empty_in  = 1'b0;
      framing_in    = 1'b0;
      dropped_in    = 1'b0;
      popped_in     = '0;

      if (csr_valid && csr_ready) begin
         reload_in = csr_timeout_reload;
      end

      if (req_accept) begin
         unique case (mode_type'(req_mode))
            MODE_BYTE: begin
               if (armed_ff) begin
                  // take the byte as the command; drop it when there is no room
                  if (queue_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     push          = 1'b1;
                     sequence_in   = sequence_ff + 16'd1;
                     fill_count_in = fill_count_ff + CNT_W'(1);
                  end
                  armed_in = 1'b0;
               end else if (req_rx_byte == 8'd0) begin
                  armed_in   = 1'b1;
                  timeout_in = reload_ff;
               end else begin
                  framing_in = 1'b1;
               end
            end
            MODE_TICK: begin
               if (armed_ff) begin
                  if (timeout_ff != 8'd0) begin
                     timeout_in = timeout_ff - 8'd1;
                  end else begin
                     armed_in = 1'b0;
                  end
               end
            end
            MODE_POP: begin
               if (fill_count_ff == '0) begin
                  pop_empty_in = 1'b1;
               end else begin
                  pop           = 1'b1;
                  pop_valid_in  = 1'b1;
                  popped_in     = head;
                  fill_count_in = fill_count_ff - CNT_W'(1);
               end
            end
            MODE_NONE: begin
            end
            default: begin
            end
         endcase
      end

      level_in = level_of(fill_count_in);

      // hold the result until taken; load a new one on each request transfer
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   fcrq_chain u_chain (
      .clock      (clock),
      .push       (push),
      .pop        (pop),
      .fill_count (fill_count_ff),
      .push_data  (push_data),
      .head       (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff     <= TIMEOUT_RESET;
         armed_ff      <= 1'b0;
         timeout_ff    <= 8'd0;
         fill_count_ff <= '0;
         sequence_ff   <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         reload_ff     <= reload_in;
         armed_ff      <= armed_in;
         timeout_ff    <= timeout_in;
         fill_count_ff <= fill_count_in;
         sequence_ff   <= sequence_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         level_ff     <= level_in;
         pop_valid_ff <= pop_valid_in;
         pop_empty_ff <= pop_empty_in;
         popped_ff    <= popped_in;
         framing_ff   <= framing_in;
         dropped_ff   <= dropped_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_queue_level     = level_ff;
   assign rsp_pop_valid       = pop_valid_ff;
   assign rsp_pop_empty_error = pop_empty_ff;
   assign rsp_out_command     = popped_ff.command;
   assign rsp_out_sequence    = popped_ff.sequence_num;
   assign rsp_out_null_flag   = popped_ff.null_flag;
   assign rsp_framing_error   = framing_ff;
   assign rsp_dropped_full    = dropped_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count exceeds queue depth");

   a_pop_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pop_valid && rsp_pop_empty_error))
      else $error("pop reported both valid and empty");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped_full) |-> (rsp_queue_level == LEVEL_FULL))
      else $error("command dropped while queue not full");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_mode == MODE_POP) && (fill_count_ff != '0))
      |=> (fill_count_ff == $past(fill_count_ff) - CNT_W'(1)))
      else $error("pop did not remove one entry");
`endif

endmodule
